### sv/lmbr_pkg.sv
// Shared types and constants for the LED matrix blink and refresh block.
`default_nettype none
package lmbr_pkg;

  localparam int NUM_ROWS = 8;
  localparam int ROW_W    = 8;
  localparam int GRID_W   = 64;
  localparam int ROW_IDX_W = 3;
  localparam int DIGIT_W  = 4;

  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;

  localparam logic [ROW_W-1:0] ONE_BIT = 8'h01;

  typedef enum logic [2:0] {
    CMD_ON         = 3'd0,
    CMD_OFF        = 3'd1,
    CMD_BLINK      = 3'd2,
    CMD_ALL_OFF    = 3'd3,
    CMD_STEADY     = 3'd4,
    CMD_BLINK_GRID = 3'd5,
    CMD_TICK       = 3'd6,
    CMD_FLUSH      = 3'd7
  } cmd_op_t;

  // Decoded command as it sits in the queue.
  typedef struct packed {
    cmd_op_t               op;
    logic [ROW_IDX_W-1:0]  row;
    logic [ROW_W-1:0]      col;
    logic                  flush;
    logic [GRID_W-1:0]     grid;
  } cmd_t;

  typedef enum logic {
    BK_RUN   = 1'b0,
    BK_FLUSH = 1'b1
  } back_state_t;

endpackage
`default_nettype wire

### sv/lmbr_front.sv
// Command front end: accepts beats and decodes them into queue entries.
`default_nettype none
module lmbr_front (
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // led_index[5:0], flush_now[6], grid_pattern[70:7], zero pad [71]
  input  wire logic [lmbr_pkg::IN_DATA_W-1:0] s_tdata,
  // func[2:0]
  input  wire logic [lmbr_pkg::IN_USER_W-1:0] s_tuser,
  output logic                                push_valid,
  input  wire logic                           push_ready,
  output lmbr_pkg::cmd_t                      push_data
);
  import lmbr_pkg::*;

  logic [5:0]        led_index;
  logic              flush_now;
  logic [GRID_W-1:0] pattern;
  cmd_op_t           op;

  assign led_index = s_tdata[5:0];
  assign flush_now = s_tdata[6];
  assign pattern   = s_tdata[70:7];
  assign op        = cmd_op_t'(s_tuser);

  assign push_valid = s_tvalid;
  assign s_tready   = push_ready;

  always_comb begin
    push_data.op  = op;
    // LED n sits in row 7 - n/8, bit 7 - n%8
    push_data.row = ~led_index[5:3];
    push_data.col = ONE_BIT << (~led_index[2:0]);
    // reverse the whole pattern so that byte i belongs to row i
    for (int i = 0; i < GRID_W; i++) begin
      push_data.grid[i] = pattern[GRID_W-1-i];
    end
    unique case (op)
      CMD_ON, CMD_OFF:                                    push_data.flush = flush_now;
      CMD_ALL_OFF, CMD_STEADY, CMD_BLINK_GRID, CMD_FLUSH: push_data.flush = 1'b1;
      default:                                            push_data.flush = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

### sv/lmbr_queue.sv
// Short command queue between the front end and the row engine.
`default_nettype none
module lmbr_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire lmbr_pkg::cmd_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output lmbr_pkg::cmd_t      pop_data
);
  import lmbr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### sv/lmbr_back.sv
// Row engine: holds the grid state, runs commands and scans dirty rows out.
`default_nettype none
module lmbr_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire lmbr_pkg::cmd_t                cmd,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lmbr_pkg::DIGIT_W-1:0]       digit_register,
  output logic [lmbr_pkg::ROW_W-1:0]         row_bits,
  output logic                               last
);
  import lmbr_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  logic [ROW_W-1:0]     row_lit        [NUM_ROWS];
  logic [ROW_W-1:0]     row_lit_next   [NUM_ROWS];
  logic [ROW_W-1:0]     row_blink      [NUM_ROWS];
  logic [ROW_W-1:0]     row_blink_next [NUM_ROWS];
  logic [NUM_ROWS-1:0]  row_dirty;
  logic [NUM_ROWS-1:0]  row_dirty_next;

  logic                 exec;
  logic                 emit;
  logic                 any_blink;
  logic                 flush_go;
  logic [ROW_IDX_W-1:0] sel;
  logic [NUM_ROWS-1:0]  rest_dirty;
  logic                 sel_last;

  // lowest dirty row goes out first
  always_comb begin
    sel = '0;
    for (int i = NUM_ROWS - 1; i >= 0; i--) begin
      if (row_dirty[i]) begin
        sel = ROW_IDX_W'(i);
      end
    end
  end

  assign rest_dirty = row_dirty & (row_dirty - 1'b1);
  assign sel_last   = (rest_dirty == '0);

  always_comb begin
    any_blink = 1'b0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      any_blink = any_blink | (row_blink[i] != '0);
    end
  end

  assign flush_go = cmd.flush || ((cmd.op == CMD_TICK) && any_blink);

  // control outputs of the sequencer
  always_comb begin
    exec = 1'b0;
    emit = 1'b0;
    unique case (state)
      BK_RUN:   exec = cmd_valid;
      BK_FLUSH: emit = (row_dirty != '0) && (!out_valid || out_ready);
      default: begin
        exec = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  assign cmd_ready = exec;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_RUN: begin
        if (exec && flush_go) begin
          state_next = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (row_dirty == '0 || (emit && sel_last)) begin
          state_next = BK_RUN;
        end
      end
      default: state_next = BK_RUN;
    endcase
  end

  // grid state update
  always_comb begin
    logic [ROW_W-1:0] m;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] l;
    m = '0;
    b = '0;
    l = '0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      row_lit_next[i]   = row_lit[i];
      row_blink_next[i] = row_blink[i];
    end
    row_dirty_next = row_dirty;
    if (exec) begin
      case (cmd.op)
        CMD_ON: begin
          row_lit_next[cmd.row]   = row_lit[cmd.row] | cmd.col;
          row_blink_next[cmd.row] = row_blink[cmd.row] & ~cmd.col;
          row_dirty_next[cmd.row] = 1'b1;
        end
        CMD_OFF: begin
          row_lit_next[cmd.row]   = row_lit[cmd.row] & ~cmd.col;
          row_blink_next[cmd.row] = row_blink[cmd.row] & ~cmd.col;
          row_dirty_next[cmd.row] = 1'b1;
        end
        CMD_BLINK: begin
          row_blink_next[cmd.row] = row_blink[cmd.row] | cmd.col;
          row_lit_next[cmd.row]   = row_lit[cmd.row] | row_blink[cmd.row] | cmd.col;
        end
        CMD_ALL_OFF: begin
          for (int i = 0; i < NUM_ROWS; i++) begin
            row_blink_next[i] = '0;
            if (row_lit[i] != '0) begin
              row_lit_next[i]   = '0;
              row_dirty_next[i] = 1'b1;
            end
          end
        end
        CMD_STEADY: begin
          for (int i = 0; i < NUM_ROWS; i++) begin
            m = cmd.grid[i*ROW_W +: ROW_W];
            b = row_blink[i];
            row_lit_next[i]   = (row_lit[i] & b) | (m & ~b);
            row_dirty_next[i] = 1'b1;
          end
        end
        CMD_BLINK_GRID: begin
          for (int i = 0; i < NUM_ROWS; i++) begin
            m = cmd.grid[i*ROW_W +: ROW_W];
            l = row_lit[i] | m;
            row_lit_next[i]   = l & ~(row_blink[i] & ~m);
            row_blink_next[i] = m;
            row_dirty_next[i] = 1'b1;
          end
        end
        CMD_TICK: begin
          for (int i = 0; i < NUM_ROWS; i++) begin
            if (row_blink[i] != '0) begin
              row_lit_next[i]   = row_lit[i] ^ row_blink[i];
              row_dirty_next[i] = 1'b1;
            end
          end
        end
        default: begin
          row_dirty_next = row_dirty;
        end
      endcase
    end
    if (emit) begin
      row_dirty_next[sel] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_RUN;
      row_dirty <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_ROWS; i++) begin
        row_lit[i]   <= '0;
        row_blink[i] <= '0;
      end
    end else begin
      state     <= state_next;
      row_dirty <= row_dirty_next;
      for (int i = 0; i < NUM_ROWS; i++) begin
        row_lit[i]   <= row_lit_next[i];
        row_blink[i] <= row_blink_next[i];
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame register, loaded only when free or being taken
  always_ff @(posedge clk) begin
    if (emit) begin
      digit_register <= DIGIT_W'(sel) + 1'b1;
      row_bits       <= row_lit[sel];
      last           <= sel_last;
    end
  end

endmodule
`default_nettype wire

### sv/led_matrix_blink_refresh.sv
// Top level of the 8x8 LED grid manager with blink and dirty-row refresh.
//
//  port group  dir  tdata / tuser                         meaning
//  s_*         in   tuser func, tdata led/flush/pattern   one command per beat
//  m_*         out  tdata digit/row bits, tlast            one row frame per beat
//
// A command that needs no flush leaves the row engine in its run state; a flushing
// command moves it to the flush state, which it leaves once no dirty row remains,
// with the row scan emitting one frame per cycle into the output register while
// m_tready keeps that register free. An empty flush also enters the flush state.
// Reset clears all rows, blink masks and dirty flags at once. Commands queue in
// front of the engine while a flush waits on m_tready.
`default_nettype none
module led_matrix_blink_refresh #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // led_index[5:0], flush_now[6], grid_pattern[70:7], zero pad [71]
  input  wire logic [lmbr_pkg::IN_DATA_W-1:0]  s_tdata,
  // func[2:0]
  input  wire logic [lmbr_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // digit_register[3:0], row_bits[11:4], zero pad [15:12]
  output logic [lmbr_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tlast
);
  import lmbr_pkg::*;

  logic                 push_valid;
  logic                 push_ready;
  cmd_t                 push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  cmd_t                 pop_data;
  logic [DIGIT_W-1:0]   digit_register;
  logic [ROW_W-1:0]     row_bits;

  lmbr_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lmbr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lmbr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (pop_valid),
    .cmd_ready      (pop_ready),
    .cmd            (pop_data),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .digit_register (digit_register),
    .row_bits       (row_bits),
    .last           (m_tlast)
  );

  assign m_tdata = {(OUT_DATA_W - DIGIT_W - ROW_W)'(0), row_bits, digit_register};

endmodule
`default_nettype wire
